// ===== hw/rtl/tclr_pkg.sv =====
// Shared types and constants for the text console line ring.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
package tclr_pkg;

   localparam logic [7:0] LEAD_MIN = 8'h81;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [2:0] REG_LINE_WIDTH = 3'd0;
   localparam logic [2:0] REG_LINE_COUNT = 3'd1;
   localparam logic [2:0] REG_TAB_CODE   = 3'd2;
   localparam logic [2:0] REG_TRUNCATE   = 3'd3;
   localparam logic [2:0] REG_STOP       = 3'd4;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_HOME,        // cursor to line 0, column 0
      OP_TERM,        // write zero terminator at cursor
      OP_ADVANCE,     // column 0, next line, scroll bookkeeping
      OP_PUT_C0,      // write first character cell at cursor
      OP_PUT_C1,      // write second character cell at cursor plus one
      OP_COL_ADD,     // column plus character width
      OP_TAB_CELL,    // write a space and step the column
      OP_READ         // issue a store read
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] width;   // character width for OP_COL_ADD
   } dp_cmd_type;

   typedef struct packed {
      logic col_full;     // column at or past the used width
      logic no_fit;       // column plus width exceeds used width
      logic too_wide;     // width exceeds used width
      logic beyond;       // line at or past the used line count
      logic tab_done;     // tab stop or line end reached after a tab cell
   } dp_status_type;

endpackage

// ===== hw/rtl/tclr_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module tclr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // One access a cycle; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule

// ===== hw/rtl/tclr_datapath.sv =====
// Datapath: cursor, ring start, scroll counter and the text store.
// Depends on tclr_pkg and tclr_ram.
`timescale 1ns / 1ps
module tclr_datapath #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_LINES   = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tclr_pkg::dp_cmd_type    cmd,
   input  logic [7:0]              c0,
   input  logic [7:0]              c1,
   input  logic [5:0]              rd_line,
   input  logic [7:0]              rd_col,
   input  logic [7:0]              line_width,
   input  logic [6:0]              line_count,
   input  logic [1:0]              tab_code,
   input  logic                    stop_at_bottom,
   output tclr_pkg::dp_status_type status,
   output logic [6:0]              cursor_line,
   output logic [7:0]              cursor_column,
   output logic [5:0]              oldest_line,
   output logic [31:0]             total_lines,
   output logic [7:0]              cell_value
);
   import tclr_pkg::*;

   localparam int ROW   = MAX_COLUMNS + 1;
   localparam int DEPTH = MAX_LINES * ROW;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = $clog2(MAX_LINES + 1);
   localparam int CW    = $clog2(MAX_COLUMNS + 2);

   logic [LW-1:0] line_ff, line_in;
   logic [CW-1:0] col_ff, col_in;
   logic          col_hi_ff, col_hi_in;
   logic [LW-1:0] start_ff, start_in;
   logic [31:0]   scroll_ff, scroll_in;
   logic          rd_oob_ff;
   logic          rd_pend_ff;
   logic [7:0]    cell_ff;

   logic [CW-1:0] uw;
   logic [LW-1:0] ul;
   logic [LW-1:0] line_inc;
   logic [CW:0]   col_sum;
   logic [CW-1:0] cell_col;
   logic [7:0]    cell_data;
   logic          wr_req;
   logic [LW-1:0] a_line;
   logic [CW-1:0] a_col;
   logic          a_ok;
   logic [AW-1:0] addr;
   logic          wr_en;
   logic [7:0]    ram_q;
   logic [7:0]    stop_mask;
   logic [CW-1:0] col_next1;
   logic [31:0]   used;
   logic [LW-1:0] sinc;
   logic [7:0]    cell_now;

   // Clamp the configured width and line count.
   always_comb begin
      if (line_width == 8'd0) begin
         uw = CW'(1);
      end else if (32'(line_width) > 32'(MAX_COLUMNS)) begin
         uw = CW'(MAX_COLUMNS);
      end else begin
         uw = CW'(line_width);
      end
      if (line_count == 7'd0) begin
         ul = LW'(1);
      end else if (32'(line_count) > 32'(MAX_LINES)) begin
         ul = LW'(MAX_LINES);
      end else begin
         ul = LW'(line_count);
      end
   end

   assign col_sum   = {1'b0, col_ff} + (CW+1)'(cmd.width);
   assign col_next1 = col_ff + CW'(1);
   assign stop_mask = (8'd2 << tab_code) - 8'd1;
   assign line_inc  = line_ff + LW'(1);

   // Status towards the controller. A column that has run past the counter's
   // range is held by col_hi_ff and counts as far beyond the line end.
   always_comb begin
      status.col_full = col_hi_ff || (col_ff >= uw);
      status.no_fit   = col_hi_ff || (col_sum > {1'b0, uw});
      status.too_wide = CW'(cmd.width) > uw;
      status.beyond   = line_ff >= ul;
      status.tab_done = col_hi_ff || (col_next1 >= uw)
                        || ((8'(col_next1) & stop_mask) == 8'd0);
   end

   // Store write selection.
   always_comb begin
      wr_req    = 1'b0;
      cell_col  = col_ff;
      cell_data = 8'd0;
      case (cmd.op)
         OP_TERM, OP_ADVANCE: wr_req = 1'b1;
         OP_PUT_C0: begin
            wr_req    = 1'b1;
            cell_data = c0;
         end
         OP_PUT_C1: begin
            wr_req    = 1'b1;
            cell_col  = col_next1;
            cell_data = c1;
         end
         OP_TAB_CELL: begin
            wr_req    = 1'b1;
            cell_data = CH_SPACE;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.op == OP_READ) begin
         a_line = LW'(rd_line);
         a_col  = CW'(rd_col);
         a_ok   = (32'(a_line) < 32'(MAX_LINES)) && (32'(a_col) <= 32'(MAX_COLUMNS));
      end else begin
         a_line = line_ff;
         a_col  = cell_col;
         a_ok   = !col_hi_ff && (32'(a_line) < 32'(MAX_LINES))
                  && (32'(a_col) <= 32'(MAX_COLUMNS));
      end
      addr  = a_ok ? AW'(32'(a_line) * ROW + 32'(a_col)) : '0;
      wr_en = wr_req && a_ok;
   end

   tclr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .addr   (addr),
      .wr_data(cell_data),
      .rd_data(ram_q)
   );

   // Cursor, ring start and scroll count updates.
   always_comb begin
      line_in   = line_ff;
      col_in    = col_ff;
      col_hi_in = col_hi_ff;
      start_in  = start_ff;
      scroll_in = scroll_ff;
      sinc      = start_ff + LW'(1);
      case (cmd.op)
         OP_HOME: begin
            line_in   = '0;
            col_in    = '0;
            col_hi_in = 1'b0;
         end
         OP_ADVANCE: begin
            col_in    = '0;
            col_hi_in = 1'b0;
            if (line_inc >= ul && !stop_at_bottom) begin
               line_in = '0;
            end else begin
               line_in = line_inc;
            end
            if (line_in == start_ff) begin
               scroll_in = scroll_ff + 32'd1;
               start_in  = (sinc >= ul) ? '0 : sinc;
            end
         end
         OP_COL_ADD:  col_in = CW'(col_sum);
         OP_TAB_CELL: begin
            col_in    = col_next1;
            col_hi_in = col_hi_ff || (&col_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= '0;
         col_ff     <= '0;
         col_hi_ff  <= 1'b0;
         start_ff   <= '0;
         scroll_ff  <= '0;
         rd_oob_ff  <= 1'b0;
         rd_pend_ff <= 1'b0;
         cell_ff    <= 8'd0;
      end else begin
         line_ff    <= line_in;
         col_ff     <= col_in;
         col_hi_ff  <= col_hi_in;
         start_ff   <= start_in;
         scroll_ff  <= scroll_in;
         rd_oob_ff  <= !a_ok;
         rd_pend_ff <= cmd.op == OP_READ;
         if (rd_pend_ff) begin
            cell_ff <= cell_now;
         end
      end
   end

   // Read data is valid the cycle after the read and is held from then on.
   assign cell_now = rd_oob_ff ? 8'd0 : ram_q;

   // Result fields.
   always_comb begin
      if (line_ff >= start_ff) begin
         used = 32'(line_ff) - 32'(start_ff);
      end else begin
         used = 32'(line_ff) + 32'(ul) - 32'(start_ff);
      end
   end

   assign total_lines   = used + {31'd0, (col_ff != '0) || col_hi_ff} + scroll_ff;
   assign cursor_line   = 7'(line_ff);
   assign cursor_column = 8'(col_ff);
   assign oldest_line   = 6'(start_ff);
   assign cell_value    = rd_pend_ff ? cell_now : cell_ff;
endmodule

// ===== hw/rtl/tclr_control.sv =====
// Controller: decodes one beat into a sequence of datapath operations.
// Depends on tclr_pkg.
`timescale 1ns / 1ps
module tclr_control (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    in_command,
   input  logic [7:0]              in_byte,
   input  logic                    in_eos,
   input  logic                    truncate_lines,
   input  logic                    stop_at_bottom,
   input  tclr_pkg::dp_status_type status,
   output tclr_pkg::dp_cmd_type    cmd,
   output logic [7:0]              c0,
   output logic [7:0]              c1,
   output logic                    done,
   output logic                    is_read,
   output logic                    dropped,
   input  logic                    rsp_free
);
   import tclr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_CHECK, S_DECODE, S_FIT, S_FIT_ADV, S_STOP_CHK, S_WRITE0, S_WRITE1,
      S_COLADD, S_AFTER, S_TAB, S_DONE
   } state_type;

   state_type  state_ff;
   logic [7:0] byte_ff, lead_ff;
   logic       eos_ff, cmd_ff;
   logic       lead_pend_ff, skip_ff, wrapped_ff;
   logic [1:0] width_ff;
   logic       drop_ff;

   assign req_tready = state_ff == S_IDLE;
   assign done       = (state_ff == S_DONE) && rsp_free;
   assign is_read    = cmd_ff;
   assign dropped    = drop_ff;

   // Combinational operation for the current state.
   always_comb begin
      cmd.op    = OP_NONE;
      cmd.width = width_ff;
      case (state_ff)
         S_CHECK:  if (status.beyond && !stop_at_bottom) cmd.op = OP_HOME;
         S_FIT_ADV: cmd.op = OP_ADVANCE;
         S_WRITE0: cmd.op = OP_PUT_C0;
         S_WRITE1: cmd.op = OP_PUT_C1;
         S_COLADD: cmd.op = OP_COL_ADD;
         S_TAB:    cmd.op = OP_TAB_CELL;
         S_AFTER: begin
            if (status.col_full) begin
               if (!truncate_lines) cmd.op = OP_ADVANCE;
            end else if (eos_ff) begin
               cmd.op = OP_TERM;
            end
         end
         S_DECODE: begin
            if (skip_ff) begin
               if (byte_ff == CH_NL) cmd.op = OP_ADVANCE;
            end else if (!lead_pend_ff && !(wrapped_ff && byte_ff == CH_NL)
                         && byte_ff == CH_NL) begin
               cmd.op = OP_ADVANCE;
            end
         end
         S_IDLE:   if (req_tvalid && req_tready && in_command) cmd.op = OP_READ;
         default: ;
      endcase
   end

   assign c0 = lead_pend_ff ? lead_ff : byte_ff;
   assign c1 = lead_pend_ff ? byte_ff : 8'd0;

   // Sequencer state and flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lead_pend_ff <= 1'b0;
         skip_ff      <= 1'b0;
         wrapped_ff   <= 1'b0;
         lead_ff      <= 8'd0;
         drop_ff      <= 1'b0;
         cmd_ff       <= 1'b0;
         eos_ff       <= 1'b0;
         byte_ff      <= 8'd0;
         width_ff     <= 2'd1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  byte_ff <= in_byte;
                  eos_ff  <= in_eos;
                  cmd_ff  <= in_command;
                  drop_ff <= 1'b0;
                  state_ff <= in_command ? S_DONE : S_CHECK;
               end
            end
            S_CHECK: begin
               if (stop_at_bottom && status.beyond) begin
                  lead_pend_ff <= 1'b0;
                  skip_ff      <= 1'b0;
                  wrapped_ff   <= 1'b0;
                  drop_ff      <= 1'b1;
                  state_ff     <= S_DONE;
               end else begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               state_ff <= S_DONE;
               if (skip_ff) begin
                  if (byte_ff == CH_NL || eos_ff) skip_ff <= 1'b0;
                  if (byte_ff != CH_NL) drop_ff <= 1'b1;
                  wrapped_ff <= 1'b0;
               end else if (lead_pend_ff) begin
                  wrapped_ff <= 1'b0;
                  width_ff   <= 2'd2;
                  state_ff   <= S_FIT;
               end else if (wrapped_ff && byte_ff == CH_NL) begin
                  wrapped_ff <= 1'b0;
                  drop_ff    <= 1'b1;
               end else begin
                  wrapped_ff <= 1'b0;
                  if (byte_ff == CH_TAB) begin
                     state_ff <= S_TAB;
                  end else if (byte_ff >= LEAD_MIN && byte_ff != CH_NL) begin
                     if (eos_ff) begin
                        lead_ff      <= byte_ff;
                        lead_pend_ff <= 1'b1;
                        byte_ff      <= 8'd0;
                        width_ff     <= 2'd2;
                        state_ff     <= S_FIT;
                     end else begin
                        lead_ff      <= byte_ff;
                        lead_pend_ff <= 1'b1;
                     end
                  end else if (byte_ff != CH_NL) begin
                     width_ff <= 2'd1;
                     state_ff <= S_FIT;
                  end
               end
            end
            S_FIT: begin
               if (status.no_fit) begin
                  if (truncate_lines) begin
                     if (!eos_ff) skip_ff <= 1'b1;
                     drop_ff      <= 1'b1;
                     lead_pend_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else if (status.too_wide) begin
                     drop_ff      <= 1'b1;
                     lead_pend_ff <= 1'b0;
                     state_ff     <= S_DONE;
                  end else begin
                     state_ff <= S_FIT_ADV;
                  end
               end else begin
                  state_ff <= S_WRITE0;
               end
            end
            S_FIT_ADV: state_ff <= S_STOP_CHK;
            S_STOP_CHK: begin
               // Check for the stopped case after an advance.
               if (stop_at_bottom && status.beyond) begin
                  drop_ff      <= 1'b1;
                  lead_pend_ff <= 1'b0;
                  state_ff     <= S_DONE;
               end else begin
                  state_ff <= S_WRITE0;
               end
            end
            S_WRITE0: state_ff <= (width_ff == 2'd2) ? S_WRITE1 : S_COLADD;
            S_WRITE1: state_ff <= S_COLADD;
            S_COLADD: state_ff <= S_AFTER;
            S_TAB: if (status.tab_done) state_ff <= S_AFTER;
            S_AFTER: begin
               if (status.col_full && !truncate_lines) begin
                  if (!eos_ff) wrapped_ff <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  if (status.col_full && !eos_ff) skip_ff <= 1'b1;
                  state_ff <= S_DONE;
               end
               lead_pend_ff <= 1'b0;
            end
            // Wait here until the result register can take the beat.
            S_DONE: if (rsp_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hw/rtl/text_console_line_ring.sv =====
// Text console line ring, top level: streaming ports, registers, controller.
// A read goes from acceptance straight to the done state; a put steps through the
// check, decode, fit, write, column add and after states; a tab writes its space
// cells in turn, as every cell uses the one store port. The next beat can be taken
// in the cycle after the result is registered; a waiting result stalls the input side.
// Reset is synchronous active high; the text store is not cleared.
`timescale 1ns / 1ps
module text_console_line_ring #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_LINES   = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,  // byte_value[7:0], end_of_string, read_line, read_column
   input  logic         req_tuser,  // command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,  // cursor_line, cursor_column, oldest_line, total_lines,
                                    // byte_dropped, cell_value
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_data
);
   import tclr_pkg::*;

   logic [7:0] width_ff;
   logic [6:0] count_ff;
   logic [1:0] tab_ff;
   logic       trunc_ff, stop_ff;
   logic       rsp_valid_ff;
   logic [63:0] rsp_data_ff;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic [7:0]    c0, c1, cell_q;
   logic [6:0]    cl;
   logic [7:0]    cc;
   logic [5:0]    ol;
   logic [31:0]   tl;
   logic          done, is_read, dropped;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 8'd64;
         count_ff <= 7'd32;
         tab_ff   <= 2'd1;
         trunc_ff <= 1'b0;
         stop_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_LINE_WIDTH: width_ff <= csr_data;
            REG_LINE_COUNT: count_ff <= csr_data[6:0];
            REG_TAB_CODE:   tab_ff   <= csr_data[1:0];
            REG_TRUNCATE:   trunc_ff <= csr_data[0];
            REG_STOP:       stop_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   tclr_control u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .in_command(req_tuser), .in_byte(req_tdata[7:0]), .in_eos(req_tdata[8]),
      .truncate_lines(trunc_ff), .stop_at_bottom(stop_ff),
      .status(status), .cmd(cmd), .c0(c0), .c1(c1),
      .done(done), .is_read(is_read), .dropped(dropped),
      .rsp_free(!rsp_valid_ff || rsp_tready)
   );

   tclr_datapath #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_LINES(MAX_LINES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .c0(c0), .c1(c1),
      .rd_line(req_tdata[14:9]), .rd_col(req_tdata[22:15]),
      .line_width(width_ff), .line_count(count_ff), .tab_code(tab_ff),
      .stop_at_bottom(stop_ff), .status(status),
      .cursor_line(cl), .cursor_column(cc), .oldest_line(ol),
      .total_lines(tl), .cell_value(cell_q)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= {2'b0, (is_read ? cell_q : 8'd0), dropped, tl, ol, cc, cl};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule

// ===== hw/rtl/tclr_checker.sv =====
// Port-level checker for the text console line ring, bound to the top level.
// Depends on the top level's ports only.
`timescale 1ns / 1ps
module tclr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   // Results hold while stalled.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Acceptance stops further acceptance next cycle.
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("two items in work");

   // Handshake outputs are always known out of reset.
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tready, rsp_tvalid}))
      else $error("handshake output unknown");
endmodule

bind text_console_line_ring tclr_checker u_chk (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the text console line ring.
// Depends on tclr_pkg and text_console_line_ring; drives all three ports and
// checks every response beat against a predictor of the line ring.
`timescale 1ns / 1ps
module tb_top;
   import tclr_pkg::*;

   localparam int NCOLS      = 128;
   localparam int NLINES     = 64;
   localparam int WATCH_MAX  = 2000;
   localparam int SETTLE     = 30;
   localparam bit CMD_PUT    = 1'b0;
   localparam bit CMD_READ   = 1'b1;

   typedef struct {
      bit [6:0]  cur_line;
      bit [7:0]  cur_col;
      bit [5:0]  oldest;
      bit [31:0] total;
      bit        dropped;
      bit [7:0]  cell_val;
   } console_result_type;

   // Predictor of the line ring plus the queue of expected responses.
   class console_scoreboard;
      bit [7:0]    cells [NLINES][NCOLS+1];
      bit          seen [NLINES][NCOLS+1];
      int unsigned seen_list [$];
      int unsigned width_reg, count_reg, tab_reg, trunc_reg, stop_reg;
      int unsigned wl, wc, rs, scrolled;
      bit [7:0]    held;
      bit          lead_wait, skipping, wrapped;
      console_result_type awaited [$];
      int unsigned mismatches, checked;

      function new();
         width_reg = 64;
         count_reg = 32;
         tab_reg   = 1;
      endfunction

      function int unsigned eff_width();
         if (width_reg < 1) return 1;
         if (width_reg > NCOLS) return NCOLS;
         return width_reg;
      endfunction

      function int unsigned eff_lines();
         if (count_reg < 1) return 1;
         if (count_reg > NLINES) return NLINES;
         return count_reg;
      endfunction

      function void set_reg(bit [2:0] idx, bit [7:0] v);
         case (idx)
            REG_LINE_WIDTH: width_reg = v;
            REG_LINE_COUNT: count_reg = v & 8'h7F;
            REG_TAB_CODE:   tab_reg   = v & 8'h03;
            REG_TRUNCATE:   trunc_reg = v & 8'h01;
            REG_STOP:       stop_reg  = v & 8'h01;
            default: ;
         endcase
      endfunction

      function void store_cell(int unsigned ln, int unsigned col, bit [7:0] v);
         if (ln < NLINES && col <= NCOLS) begin
            cells[ln][col] = v;
            if (!seen[ln][col]) begin
               seen[ln][col] = 1'b1;
               seen_list.push_back(ln * (NCOLS + 1) + col);
            end
         end
      endfunction

      // Terminate the line, step down and scroll when the oldest line is hit.
      function void advance_line();
         store_cell(wl, wc, 8'h00);
         wc = 0;
         wl++;
         if (wl >= eff_lines() && stop_reg == 0) wl = 0;
         if (wl == rs) begin
            scrolled++;
            rs++;
            if (rs >= eff_lines()) rs = 0;
         end
      endfunction

      function void settle_after_write(bit eos);
         if (wc >= eff_width()) begin
            if (trunc_reg != 0) begin
               if (!eos) skipping = 1'b1;
            end else begin
               advance_line();
               if (!eos) wrapped = 1'b1;
            end
         end else if (eos) begin
            store_cell(wl, wc, 8'h00);
         end
      endfunction

      function bit place_char(bit [7:0] c0, bit [7:0] c1, int unsigned n, bit eos);
         if (wc + n > eff_width()) begin
            if (trunc_reg != 0) begin
               if (!eos) skipping = 1'b1;
               return 1'b1;
            end
            if (n > eff_width()) return 1'b1;
            advance_line();
            if (stop_reg != 0 && wl >= eff_lines()) return 1'b1;
         end
         store_cell(wl, wc, c0);
         if (n == 2) store_cell(wl, wc + 1, c1);
         wc += n;
         settle_after_write(eos);
         return 1'b0;
      endfunction

      function void place_tab(bit eos);
         int unsigned stop_mask;
         stop_mask = (2 << tab_reg) - 1;
         do begin
            store_cell(wl, wc, CH_SPACE);
            wc++;
            if (wc >= eff_width()) break;
         end while ((wc & stop_mask) != 0);
         settle_after_write(eos);
      endfunction

      function bit take_byte(bit [7:0] b, bit eos);
         bit drop;
         drop = 1'b0;
         if (wl >= eff_lines() && stop_reg == 0) begin
            wl = 0;
            wc = 0;
         end
         if (stop_reg != 0 && wl >= eff_lines()) begin
            lead_wait = 1'b0;
            skipping  = 1'b0;
            wrapped   = 1'b0;
            return 1'b1;
         end
         if (skipping) begin
            if (b == CH_NL) begin
               skipping = 1'b0;
               advance_line();
            end else begin
               drop = 1'b1;
            end
            if (eos) skipping = 1'b0;
            wrapped = 1'b0;
            return drop;
         end
         if (lead_wait) begin
            lead_wait = 1'b0;
            wrapped   = 1'b0;
            return place_char(held, b, 2, eos);
         end
         // A newline straight after an automatic wrap is swallowed.
         if (wrapped && b == CH_NL) begin
            wrapped = 1'b0;
            return 1'b1;
         end
         wrapped = 1'b0;
         if (b == CH_NL) advance_line();
         else if (b == CH_TAB) place_tab(eos);
         else if (b >= LEAD_MIN) begin
            if (eos) drop = place_char(b, 8'h00, 2, eos);
            else begin
               held      = b;
               lead_wait = 1'b1;
            end
         end else drop = place_char(b, 8'h00, 1, eos);
         return drop;
      endfunction

      // Note an accepted request beat and queue the response it must cause.
      function void note_request(bit cmd, bit [7:0] b, bit eos, bit [5:0] rl, bit [7:0] rc);
         console_result_type r;
         int unsigned used;
         r.cell_val = 8'h00;
         r.dropped  = 1'b0;
         if (cmd == CMD_PUT) r.dropped = take_byte(b, eos);
         else if (rc <= NCOLS) r.cell_val = cells[rl][rc];
         if (wl >= rs) used = wl - rs;
         else used = wl + eff_lines() - rs;
         r.cur_line = wl[6:0];
         r.cur_col  = wc[7:0];
         r.oldest   = rs[5:0];
         r.total    = used + (wc != 0 ? 1 : 0) + scrolled;
         awaited.push_back(r);
      endfunction

      // Compare one response beat, field by field, with the oldest expectation.
      function void check_response(bit [63:0] d);
         console_result_type e;
         if (awaited.size() == 0) begin
            $error("response beat with nothing expected: %h", d);
            mismatches++;
            return;
         end
         e = awaited.pop_front();
         checked++;
         if (d[6:0] != e.cur_line) begin
            $error("cursor_line: expected %0d, got %0d", e.cur_line, d[6:0]);
            mismatches++;
         end
         if (d[14:7] != e.cur_col) begin
            $error("cursor_column: expected %0d, got %0d", e.cur_col, d[14:7]);
            mismatches++;
         end
         if (d[20:15] != e.oldest) begin
            $error("oldest_line: expected %0d, got %0d", e.oldest, d[20:15]);
            mismatches++;
         end
         if (d[52:21] != e.total) begin
            $error("total_lines: expected %0d, got %0d", e.total, d[52:21]);
            mismatches++;
         end
         if (d[53] != e.dropped) begin
            $error("byte_dropped: expected %0d, got %0d", e.dropped, d[53]);
            mismatches++;
         end
         if (d[61:54] != e.cell_val) begin
            $error("cell_value: expected %0d, got %0d", e.cell_val, d[61:54]);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid, req_tready, req_tuser;
   logic [23:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [7:0]  csr_data;

   console_scoreboard sb;
   int unsigned req_beats, rsp_beats, csr_beats, quiet_cycles;
   bit          send_idles, recv_idles;
   int          nl_pct, settings_done;

   text_console_line_ring #(.MAX_COLUMNS(NCOLS), .MAX_LINES(NLINES)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Beat monitor and watchdog; all values are those sampled at the edge.
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (req_tvalid && req_tready) begin
            sb.note_request(req_tuser, req_tdata[7:0], req_tdata[8], req_tdata[14:9],
                            req_tdata[22:15]);
            req_beats++;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_response(rsp_tdata);
            rsp_beats++;
         end
         if (csr_valid && csr_ready) begin
            sb.set_reg(csr_index, csr_data);
            csr_beats++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCH_MAX) begin
            $display("watchdog: no beat for %0d cycles", WATCH_MAX);
            $display("tb: failure");
            $finish;
         end
      end
   end

   function automatic int draw_wait(bit on);
      return on ? $urandom_range(0, 18) : 0;
   endfunction

   // Result side: stall before each beat, sometimes not at all.
   initial begin
      int stall;
      int unsigned seen_beats;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) recv_idles = ~recv_idles;
         stall = draw_wait(recv_idles);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         seen_beats = rsp_beats;
         wait (rsp_beats != seen_beats);
      end
   end

   // Present one request beat; valid stays high into the next beat when no gap.
   task automatic send_item(bit cmd, bit [7:0] b, bit eos, bit [5:0] rl, bit [7:0] rc);
      int gap;
      int unsigned target;
      target = req_beats + 1;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, rc, rl, eos, b};
      wait (req_beats == target);
      if ($urandom_range(0, 19) == 0) send_idles = ~send_idles;
      gap = draw_wait(send_idles);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_put(bit [7:0] b, bit eos);
      send_item(CMD_PUT, b, eos, 6'($urandom), 8'($urandom));
   endtask

   // Reads only touch cells already written, or columns past the store.
   task automatic send_read();
      int unsigned addr;
      if (sb.seen_list.size() == 0 || $urandom_range(0, 4) == 0)
         send_item(CMD_READ, 8'($urandom), 1'($urandom), 6'($urandom),
                   8'($urandom_range(NCOLS + 1, 255)));
      else begin
         addr = sb.seen_list[$urandom_range(0, sb.seen_list.size() - 1)];
         send_item(CMD_READ, 8'($urandom), 1'($urandom), 6'(addr / (NCOLS + 1)),
                   8'(addr % (NCOLS + 1)));
      end
   endtask

   // Hold the sender until every expected response is in and the block is idle.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (rsp_beats == req_beats);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_settings(bit [7:0] w, bit [7:0] c, bit [7:0] t, bit [7:0] tr,
                                 bit [7:0] st);
      bit [2:0] idx [5];
      bit [7:0] val [5];
      int unsigned target;
      idx = '{REG_LINE_WIDTH, REG_LINE_COUNT, REG_TAB_CODE, REG_TRUNCATE, REG_STOP};
      val = '{w, c, t, tr, st};
      foreach (idx[i]) begin
         target = csr_beats + 1;
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         wait (csr_beats == target);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_done++;
   endtask

   // Random text: strings of printable and random bytes, tabs, newlines and lead pairs, with reads.
   task automatic random_text(int count);
      int r;
      bit eos;
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) drain_results();
         r   = $urandom_range(0, 99);
         eos = ($urandom_range(0, 7) == 0);
         if (r < 12) send_read();
         else if (r < 12 + nl_pct) send_put(CH_NL, eos);
         else if (r < 20 + nl_pct) send_put(CH_TAB, eos);
         else if (r < 30 + nl_pct) begin
            send_put(8'($urandom_range(LEAD_MIN, 255)), 1'b0);
            send_put(8'($urandom), eos);
         end else if (r < 40 + nl_pct) send_put(8'($urandom), eos);
         else send_put(8'($urandom_range(8'h21, 8'h7E)), eos);
      end
      drain_results();
   endtask

   initial begin
      sb = new();
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= CMD_PUT;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_LINE_WIDTH;
      csr_data   <= '0;
      send_idles = 1'b1;
      recv_idles = 1'b1;
      nl_pct     = 10;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed text at the reset settings, then on a tiny ring.
      send_put("H", 1'b0);
      send_put(CH_TAB, 1'b0);
      send_put(CH_NL, 1'b0);
      drain_results();
      write_settings(8'd4, 8'd3, 8'd0, 8'd0, 8'd0);
      send_put("a", 1'b0);
      send_put("b", 1'b0);
      send_put("c", 1'b0);
      send_put("d", 1'b0);          // fills the line and wraps
      send_put(CH_NL, 1'b0);        // swallowed after the wrap
      send_put(8'h81, 1'b0);        // lead byte held
      send_put("x", 1'b0);
      send_put(CH_TAB, 1'b0);
      send_put(CH_TAB, 1'b1);
      send_put(8'hFF, 1'b1);        // lead byte ending a string
      send_put(CH_NL, 1'b0);
      send_put(CH_NL, 1'b0);        // scrolls the ring
      send_put(8'h00, 1'b0);
      send_put(8'h80, 1'b0);
      send_put(8'h7F, 1'b1);
      send_read();
      send_item(CMD_READ, 8'h00, 1'b0, 6'd63, 8'd255);
      drain_results();

      write_settings(8'd16, 8'd8, 8'd1, 8'd0, 8'd0);
      random_text(55);
      write_settings(8'd5, 8'd4, 8'd2, 8'd1, 8'd0);
      random_text(50);
      write_settings(8'd0, 8'd0, 8'd3, 8'd0, 8'd0);
      random_text(40);
      nl_pct = 30;
      write_settings(8'd128, 8'd3, 8'd3, 8'd0, 8'd1);
      random_text(55);
      write_settings(8'd255, 8'd127, 8'd0, 8'd1, 8'd1);
      random_text(40);
      nl_pct = 10;
      write_settings(8'd10, 8'd6, 8'd1, 8'd0, 8'd0);
      random_text(50);
      write_settings(8'd1, 8'd64, 8'd2, 8'd0, 8'd0);
      random_text(80);
      write_settings(8'd1, 8'd2, 8'd0, 8'd1, 8'd0);
      random_text(40);

      $display("covered %0d requests and %0d checked responses over %0d register settings",
               req_beats, sb.checked, settings_done);
      if (sb.mismatches == 0 && sb.awaited.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
